### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/b85enc_pkg.sv
// ----------------------------------------------------------------------------
// b85enc_pkg
// Types, constants and the character map shared by the base-85 encoder.
// ----------------------------------------------------------------------------
package b85enc_pkg;

  // Radix and the reciprocal used to divide a 32-bit value by it.
  // floor(x / 85) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [6:0]  RADIX       = 7'd85;
  localparam logic [31:0] RECIP       = 32'd3233857729;
  localparam int          RECIP_SHIFT = 38;

  // Number of characters per full group and digits per group.
  localparam logic [2:0] FULL_CHARS = 3'd5;
  localparam int         NUM_DIGITS = 5;

  // Punctuation part of the alphabet, digit values 62 through 84.
  localparam logic [6:0] PUNCT [23] = '{
    7'd33, 7'd35, 7'd36, 7'd37, 7'd38, 7'd40, 7'd41, 7'd42, 7'd43, 7'd45,
    7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd94, 7'd95, 7'd96, 7'd123,
    7'd124, 7'd125, 7'd126
  };

  // One completed group on its way from the front end to the converter.
  typedef struct packed {
    logic [31:0] group;
    logic [2:0]  nchars;
    logic        eom;
  } b85enc_grp_t;

  // Converted digits, most significant in element 0.
  typedef struct packed {
    logic [NUM_DIGITS-1:0][6:0] digits;
    logic [2:0]                 nchars;
    logic                       eom;
  } b85enc_res_t;

  // Maps a digit value to its ASCII character.
  function automatic logic [6:0] b85_char(input logic [6:0] d);
    logic [6:0] c;
    c = 7'd48;
    priority if (d < 7'd10) begin
      c = d + 7'd48;
    end else if (d < 7'd36) begin
      c = d + 7'd55;
    end else if (d < 7'd62) begin
      c = d + 7'd61;
    end else if (d < RADIX) begin
      c = PUNCT[5'(d - 7'd62)];
    end
    return c;
  endfunction

endpackage

### hw/rtl/b85enc_front.sv
// ----------------------------------------------------------------------------
// b85enc_front
// Collects input bytes into 32-bit groups and pushes each completed or
// final group into the queue with its character count.
// ----------------------------------------------------------------------------
module b85enc_front import b85enc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  input  logic        q_full,
  output logic        q_push,
  output b85enc_grp_t q_data
);

  logic [23:0] pending;
  logic [1:0]  pcount;
  logic [2:0]  total;
  logic        take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign total    = {1'b0, pcount} + 3'd1;

  // A group leaves on its fourth byte or at the end of the message.
  assign q_push = take && (end_of_message || total == 3'd4);

  // Left-align the collected bytes, zero padding on the right.
  always_comb begin
    unique case (pcount)
      2'd0: q_data.group = {data_byte, 24'd0};
      2'd1: q_data.group = {pending[7:0], data_byte, 16'd0};
      2'd2: q_data.group = {pending[15:0], data_byte, 8'd0};
      default: q_data.group = {pending, data_byte};
    endcase
    q_data.nchars = (total == 3'd4) ? FULL_CHARS : total + 3'd1;
    q_data.eom    = end_of_message;
  end

  // Pending byte store.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      pcount  <= '0;
    end else if (take) begin
      if (q_push) begin
        pending <= '0;
        pcount  <= '0;
      end else begin
        pending <= {pending[15:0], data_byte};
        pcount  <= total[1:0];
      end
    end
  end

endmodule

### hw/rtl/b85enc_fifo.sv
// ----------------------------------------------------------------------------
// b85enc_fifo
// Short group queue that decouples the front end from the converter.
// ----------------------------------------------------------------------------
module b85enc_fifo import b85enc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b85enc_grp_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output b85enc_grp_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  b85enc_grp_t          entries [DEPTH];
  logic [PtrW-1:0]      wr_ptr;
  logic [PtrW-1:0]      rd_ptr;
  logic [CntW-1:0]      count;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/b85enc_conv.sv
// ----------------------------------------------------------------------------
// b85enc_conv
// Splits a 32-bit group into five base-85 digits with a shared
// divide-by-85 unit: a multiply step by the reciprocal, then a step
// that takes the quotient and the remainder.
// ----------------------------------------------------------------------------
module b85enc_conv import b85enc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  b85enc_grp_t q_data,
  output logic        q_pop,
  input  logic        emit_free,
  output logic        res_valid,
  output b85enc_res_t res
);

  typedef enum logic [1:0] {CV_IDLE, CV_MUL, CV_DIV, CV_HOLD} cv_state_t;

  cv_state_t                  state;
  logic [1:0]                 step;
  logic [31:0]                x;
  logic [63:0]                prod;
  logic [NUM_DIGITS-1:0][6:0] digits;
  logic [2:0]                 nchars;
  logic                       eom;

  logic [25:0]                quot;
  logic [31:0]                rem_full;
  logic [NUM_DIGITS-1:0][6:0] digits_next;
  logic                       div_last;
  logic                       handoff;

  // Quotient from the registered product, remainder by one subtract.
  assign quot     = prod[63:RECIP_SHIFT];
  assign rem_full = x - 32'(quot) * 32'(RADIX);
  assign div_last = (state == CV_DIV) && (step == 2'd3);

  // Digits including the one produced this cycle.
  always_comb begin
    digits_next = digits;
    if (state == CV_DIV) begin
      digits_next[3'd4 - {1'b0, step}] = rem_full[6:0];
      if (step == 2'd3) begin
        digits_next[0] = quot[6:0];
      end
    end
  end

  assign res_valid     = (state == CV_HOLD) || div_last;
  assign handoff       = res_valid && emit_free;
  assign res.digits    = digits_next;
  assign res.nchars    = nchars;
  assign res.eom       = eom;
  assign q_pop         = q_valid && ((state == CV_IDLE) || handoff);

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
      step  <= '0;
    end else begin
      if (q_pop) begin
        state <= CV_MUL;
        step  <= '0;
      end else if (handoff) begin
        state <= CV_IDLE;
      end else if (div_last) begin
        state <= CV_HOLD;
      end else if (state == CV_MUL) begin
        state <= CV_DIV;
      end else if (state == CV_DIV) begin
        state <= CV_MUL;
        step  <= step + 2'd1;
      end
    end
  end

  // Payload: working value, product, digits and group attributes.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      x      <= q_data.group;
      nchars <= q_data.nchars;
      eom    <= q_data.eom;
    end else if (state == CV_DIV) begin
      x <= 32'(quot);
    end
    if (state == CV_MUL) begin
      prod <= 64'(x) * 64'(RECIP);
    end
    if (state == CV_DIV) begin
      digits <= digits_next;
    end
  end

endmodule

### hw/rtl/b85enc_emit.sv
// ----------------------------------------------------------------------------
// b85enc_emit
// Holds one converted group and sends its characters, most significant
// first, through a registered output stage.
// ----------------------------------------------------------------------------
module b85enc_emit import b85enc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  input  b85enc_res_t res,
  output logic        emit_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  char_code,
  output logic        last_char
);

  logic                       busy;
  logic [2:0]                 idx;
  logic [NUM_DIGITS-1:0][6:0] digits;
  logic [2:0]                 nchars;
  logic                       eom;
  logic                       advance;
  logic                       final_one;

  assign emit_free = !busy;
  assign advance   = busy && (!out_valid || out_ready);
  assign final_one = (idx == nchars - 3'd1);

  // Control: buffer occupancy, character index, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_valid && !busy) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (advance) begin
        idx <= idx + 3'd1;
        if (final_one) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: group buffer and output character.
  always_ff @(posedge clk) begin
    if (res_valid && !busy) begin
      digits <= res.digits;
      nchars <= res.nchars;
      eom    <= res.eom;
    end
    if (advance) begin
      char_code <= b85_char(digits[idx]);
      last_char <= eom && final_one;
    end
  end

endmodule

### hw/rtl/base85_stream_encoder.sv
// ----------------------------------------------------------------------------
// base85_stream_encoder
// Streaming base-85 encoder with the RFC1924 alphabet: four bytes in,
// five characters out, short final groups give one more char than bytes.
//
//   Channel  Direction  Handshake             Payload
//   in       sink       in_valid / in_ready   data_byte, end_of_message
//   out      source     out_valid / out_ready char_code, last_char
//
// Each group goes through the divide-by-85 unit as four divisions, each
// a multiply step and a remainder step; a short final group still goes
// through all four divisions. The next group can wait in the queue, and
// bytes keep coming in, while the current group is being converted.
// Bytes are taken while the group queue has room;
// an output stall fills the character buffer, then the converter, then
// the queue. Reset is synchronous and empties every stage at once.
// ----------------------------------------------------------------------------
module base85_stream_encoder import b85enc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_code,
  output logic       last_char
);

  b85enc_grp_t push_data;
  b85enc_grp_t pop_data;
  b85enc_res_t res;
  logic        push;
  logic        full;
  logic        pop;
  logic        not_empty;
  logic        res_valid;
  logic        emit_free;

  // Front end: byte collection.
  b85enc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_full         (full),
    .q_push         (push),
    .q_data         (push_data)
  );

  // Group queue.
  b85enc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  // Digit conversion.
  b85enc_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (not_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .emit_free (emit_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // Character output.
  b85enc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .emit_free (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last_char (last_char)
  );

endmodule

### hw/rtl/b85enc_checker.sv
// ----------------------------------------------------------------------------
// b85enc_checker
// Port-level checks for the base-85 encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b85enc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] data_byte,
  input logic       end_of_message,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] char_code,
  input logic       last_char
);

  logic in_seen;

  // Tracks whether any input transfer has occurred since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_seen <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_seen <= 1'b1;
    end
  end

  // A stalled character holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(char_code) && $stable(last_char), "stalled output changed")

  // Only alphabet characters appear on the output.
  `ASSERT_IMPLIES(a_alphabet, clk, rst, out_valid, char_code >= 7'd33 && char_code != 7'd34 && char_code != 7'd39 && char_code != 7'd44 && char_code != 7'd46 && char_code != 7'd47 && char_code != 7'd58 && char_code != 7'd91 && char_code != 7'd92 && char_code != 7'd93 && char_code != 7'd127, "character outside the alphabet")

  // No character can appear before any byte was taken.
  `ASSERT_IMPLIES(a_no_invent, clk, rst, out_valid, in_seen, "output without any input")

endmodule

bind base85_stream_encoder b85enc_checker u_b85enc_checker (.*);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base85_stream_encoder. Bytes go in through the
// valid/ready input channel and grouped into messages by end_of_message.
// A predictor in the bench turns each accepted byte into the characters it
// should release, and every character transfer is checked, in order,
// against them. A short directed list covers extremes and every group
// shape, then random messages run under several idle and stall patterns,
// including one long output hold that backs the block up to its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 22;
  localparam int MAX_REPORTS    = 10;

  // One encoded character with its end-of-message mark.
  typedef struct {
    logic [6:0] code;
    logic       last;
  } b85_char_t;

  // One line of the directed stimulus; typed holds the characters when
  // they are known by hand, otherwise it is empty.
  typedef struct {
    logic [7:0] din;
    logic       eom;
    string      typed;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] char_code;
  logic       last_char;

  // The RFC1924 character set; the backtick is written as an octal escape.
  string b85_alphabet =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_\140{|}~";

  // Predictor state: bytes of the open group and how many there are.
  logic [23:0] open_bytes;
  logic [1:0]  open_count;

  b85_char_t   expected_chars[$];
  b85_char_t   step_chars[$];
  stim_row_t   directed_rows[$];

  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_go;
  logic hold_used    = 1'b0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  int   mismatches   = 0;
  int   bytes_sent;
  int   msgs_sent;
  int   chars_checked = 0;

  base85_stream_encoder u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .char_code      (char_code),
    .last_char      (last_char)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Work out the characters one byte releases into step_chars.
  function automatic void encode_byte(input logic [7:0] din, input logic eom);
    int unsigned total;
    int unsigned grp;
    int unsigned digit[5];
    int          nchars;
    b85_char_t   c;
    step_chars.delete();
    total = int'(open_count) + 1;
    if (!eom && total < 4) begin
      open_bytes = {open_bytes[15:0], din};
      open_count = 2'(total);
      return;
    end
    grp = {open_bytes, din};
    if (total < 4) begin
      grp = grp << (8 * (4 - total));
    end
    for (int k = 4; k >= 0; k--) begin
      digit[k] = grp % 85;
      grp      = grp / 85;
    end
    nchars = (total == 4) ? 5 : int'(total) + 1;
    for (int k = 0; k < nchars; k++) begin
      c.code = 7'(b85_alphabet[digit[k]]);
      c.last = eom && (k == nchars - 1);
      step_chars.push_back(c);
    end
    open_bytes = '0;
    open_count = '0;
  endfunction

  // Offer one byte, wait for its transfer, then record what it should produce.
  task automatic send_byte(input logic [7:0] din, input logic eom, input string typed);
    int        gap;
    b85_char_t c;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= din;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (eom) msgs_sent++;
    encode_byte(din, eom);
    if (typed.len() > 0) begin
      for (int i = 0; i < typed.len(); i++) begin
        c.code = 7'(typed[i]);
        c.last = eom && (i == typed.len() - 1);
        expected_chars.push_back(c);
      end
    end else begin
      foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
    end
  endtask

  function automatic void add_row(input logic [7:0] din, input logic eom, input string typed);
    stim_row_t r;
    r.din   = din;
    r.eom   = eom;
    r.typed = typed;
    directed_rows.push_back(r);
  endfunction

  // Random byte that leans toward the all-zero and all-one extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random messages until at least n bytes have gone in this phase.
  task automatic send_messages(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      for (int i = 0; i < len; i++) begin
        send_byte(pick_byte(), i == len - 1, "");
      end
      sent += len;
    end
  endtask

  // Output side: stall at random or hold off on request, and check every transfer.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected character %0d last %0b with nothing pending",
                     char_code, last_char);
          end
        end else begin
          if (expected_chars[0].code !== char_code || expected_chars[0].last !== last_char) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                       expected_chars[0].code, expected_chars[0].last, char_code, last_char);
            end
          end
          void'(expected_chars.pop_front());
        end
      end
      if (hold_go && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d characters still pending",
               quiet_cycles, expected_chars.size());
      $display("FAIL");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    data_byte      = 8'h00;
    end_of_message = 1'b0;
    open_bytes     = '0;
    open_count     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b0;
    bytes_sent     = 0;
    msgs_sent      = 0;

    // Directed part: single-byte messages, full groups with and without the
    // end mark, short final groups of two and three bytes.
    add_row(8'h00, 1'b1, "00");
    add_row(8'hFF, 1'b1, "{{");
    add_row(8'h00, 1'b0, "");
    add_row(8'h00, 1'b0, "");
    add_row(8'h00, 1'b0, "");
    add_row(8'h00, 1'b1, "00000");
    add_row(8'hFF, 1'b0, "");
    add_row(8'hFF, 1'b0, "");
    add_row(8'hFF, 1'b0, "");
    add_row(8'hFF, 1'b0, "|NsC0");
    add_row(8'h12, 1'b0, "");
    add_row(8'h34, 1'b1, "");
    add_row(8'hAB, 1'b0, "");
    add_row(8'hCD, 1'b0, "");
    add_row(8'hEF, 1'b1, "");
    add_row(8'h80, 1'b0, "");
    add_row(8'h01, 1'b0, "");
    add_row(8'h7F, 1'b0, "");
    add_row(8'hFE, 1'b1, "");
    add_row(8'h55, 1'b1, "");
    add_row(8'hAA, 1'b1, "");

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].din, directed_rows[i].eom, directed_rows[i].typed);
    end

    // Full rate both ways, with one long output hold while input keeps coming.
    hold_go = 1'b1;
    send_messages(PHASE_ITEMS);

    // Input side idles about half the time.
    send_idle_pct  = 55;
    recv_stall_pct = 0;
    send_messages(PHASE_ITEMS);

    // Output side stalls about half the time.
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    send_messages(PHASE_ITEMS);

    // Both sides hold back some of the time.
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    send_messages(PHASE_ITEMS);

    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (expected_chars.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d messages; %0d characters checked.",
             bytes_sent, msgs_sent, chars_checked);
    $display("Traffic ran at full rate, with input gaps, with output stalls, %s",
             "with both, and through one long output hold.");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d characters never seen", mismatches,
               expected_chars.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
